// File: rtl/gcse_pkg.sv
// Shared types, constants and tables for the great-circle speed estimator.
// No dependencies; imported by every module of the block.
package gcse_pkg;

  // Number formats
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS    = 24;
  localparam int HALF_TURN_DEG   = 180;
  localparam int EARTH_RADIUS_KM = 6371;

  // Field and datapath widths
  localparam int LAT_W  = 24;   // signed latitude
  localparam int LON_W  = 25;   // signed longitude
  localparam int ALT_W  = 25;   // signed altitude
  localparam int DIFF_W = 26;   // difference of two fixes
  localparam int CV_W   = 34;   // CORDIC and multiplier operand
  localparam int WORD_W = 64;   // arithmetic unit word
  localparam int IDX_W  = 5;    // arctangent table index

  // Fixed-point constants
  localparam logic signed [CV_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [CV_W-1:0]        PI_Q30          = 34'd3373259426;
  localparam logic signed [34:0]     ONE_Q30         = 35'sd1073741824;

  // Degree-to-binary-angle denominators, full and half angle
  localparam logic [WORD_W-1:0] DEN_FULL = 64'(2 * HALF_TURN_DEG) << ANGLE_FRAC_BITS;
  localparam logic [WORD_W-1:0] DEN_HALF = 64'(4 * HALF_TURN_DEG) << ANGLE_FRAC_BITS;

  // atan(2^-k) in binary angle units (2^32 per turn)
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // Arithmetic unit operations
  typedef enum logic [2:0] {
    AOP_MUL  = 3'b001,
    AOP_DIV  = 3'b010,
    AOP_SQRT = 3'b100
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic start;
    logic atan_mode;
  } cordic_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: rtl/gcse_ifs.sv
// Valid/ready channel interfaces for the position fix and speed words.
// Stand-alone; used by the top level.
interface gcse_fix_if;
  logic               valid;
  logic               ready;
  logic        [22:0] lat_magnitude;
  logic               lat_south;
  logic        [23:0] lon_magnitude;
  logic               lon_west;
  logic signed [24:0] altitude;
  logic               first_point;
  logic               last_point;

  modport source (output valid, lat_magnitude, lat_south, lon_magnitude, lon_west,
                  altitude, first_point, last_point, input ready);
  modport sink   (input valid, lat_magnitude, lat_south, lon_magnitude, lon_west,
                  altitude, first_point, last_point, output ready);
endinterface

interface gcse_speed_if;
  logic        valid;
  logic        ready;
  logic [31:0] speed;

  modport source (output valid, speed, input ready);
  modport sink   (input valid, speed, output ready);
endinterface

// File: rtl/gcse_arith.sv
// Serial arithmetic unit: shift-add multiply, restoring divide and square root,
// one bit per cycle. Depends on gcse_pkg.
module gcse_arith (
  input  logic                clk,
  input  logic                rst,
  input  gcse_pkg::arith_req_t req,
  input  logic [63:0]         opa,
  input  logic [63:0]         opb,
  output gcse_pkg::unit_stat_t stat,
  output logic [63:0]         res
);
  import gcse_pkg::*;

  logic            busy;
  logic            done;
  arith_op_t       op;
  logic [6:0]      cnt;
  logic [67:0]     acc;   // product / remainder / radicand
  logic [67:0]     sh;    // multiplicand / quotient / root
  logic [63:0]     aux;   // multiplier / divisor / root bit
  logic            neg;

  logic [67:0]     acc_next;
  logic [67:0]     sh_next;
  logic [63:0]     aux_next;
  logic [64:0]     rem_sh;
  logic [63:0]     sq_t;
  logic [CV_W-1:0] mag_a;
  logic [CV_W-1:0] mag_b;

  // Operand magnitudes for the signed multiply
  assign mag_a = opa[CV_W-1] ? CV_W'(-opa[CV_W-1:0]) : opa[CV_W-1:0];
  assign mag_b = opb[CV_W-1] ? CV_W'(-opb[CV_W-1:0]) : opb[CV_W-1:0];

  // One bit of the current operation
  always_comb begin
    acc_next = acc;
    sh_next  = sh;
    aux_next = aux;
    rem_sh   = {acc[63:0], sh[63]};
    sq_t     = sh[63:0] + aux;
    case (op)
      AOP_MUL: begin
        acc_next = aux[0] ? acc + sh : acc;
        sh_next  = {sh[66:0], 1'b0};
        aux_next = {1'b0, aux[63:1]};
      end
      AOP_DIV: begin
        if (rem_sh >= {1'b0, aux}) begin
          acc_next = {3'b0, rem_sh - {1'b0, aux}};
          sh_next  = {4'b0, sh[62:0], 1'b1};
        end else begin
          acc_next = {3'b0, rem_sh};
          sh_next  = {4'b0, sh[62:0], 1'b0};
        end
      end
      AOP_SQRT: begin
        if (acc[63:0] >= sq_t) begin
          acc_next = {4'b0, acc[63:0] - sq_t};
          sh_next  = {4'b0, 1'b0, sh[63:1]} + {4'b0, aux};
        end else begin
          acc_next = acc;
          sh_next  = {4'b0, 1'b0, sh[63:1]};
        end
        aux_next = {2'b0, aux[63:2]};
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= AOP_MUL;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        op   <= req.op;
        case (req.op)
          AOP_MUL: begin
            cnt <= 7'(CV_W - 1);
            acc <= '0;
            sh  <= {34'b0, mag_a};
            aux <= {30'b0, mag_b};
            neg <= opa[CV_W-1] ^ opb[CV_W-1];
          end
          AOP_DIV: begin
            cnt <= 7'd63;
            acc <= '0;
            sh  <= {4'b0, opa};
            aux <= opb;
            neg <= 1'b0;
          end
          default: begin
            cnt <= 7'd31;
            acc <= {4'b0, opa};
            sh  <= '0;
            aux <= 64'h4000_0000_0000_0000;
            neg <= 1'b0;
          end
        endcase
      end else if (busy) begin
        acc  <= acc_next;
        sh   <= sh_next;
        aux  <= aux_next;
        cnt  <= cnt - 7'd1;
        done <= (cnt == 7'd0);
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          case (op)
            AOP_MUL: res <= neg ? -acc_next[63:0] : acc_next[63:0];
            default: res <= sh_next[63:0];
          endcase
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: rtl/gcse_cordic.sv
// Iterative CORDIC: sine/cosine by rotation, first-quadrant arctangent by
// vectoring, one micro-rotation per cycle. Depends on gcse_pkg.
module gcse_cordic (
  input  logic                        clk,
  input  logic                        rst,
  input  gcse_pkg::cordic_req_t       req,
  input  logic [31:0]                 ang,
  input  logic signed [gcse_pkg::CV_W-1:0] xin,
  input  logic signed [gcse_pkg::CV_W-1:0] yin,
  output gcse_pkg::unit_stat_t        stat,
  output logic signed [gcse_pkg::CV_W-1:0] cos_out,
  output logic signed [gcse_pkg::CV_W-1:0] sin_out,
  output logic signed [gcse_pkg::CV_W-1:0] z_out
);
  import gcse_pkg::*;

  logic                   busy;
  logic                   done;
  logic                   atan_mode;
  logic                   flip;
  logic [IDX_W-1:0]       k;
  logic signed [CV_W-1:0] x;
  logic signed [CV_W-1:0] y;
  logic signed [CV_W-1:0] z;

  logic signed [CV_W-1:0] dx;
  logic signed [CV_W-1:0] dy;
  logic signed [CV_W-1:0] at;
  logic                   rot;
  logic signed [CV_W-1:0] x_next;
  logic signed [CV_W-1:0] y_next;
  logic signed [CV_W-1:0] z_next;
  logic                   quad_flip;
  logic [31:0]            ang_fold;

  // Fold the second and third quadrants by half a turn
  assign quad_flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
  assign ang_fold  = quad_flip ? ang + 32'h8000_0000 : ang;

  // Micro-rotation
  always_comb begin
    dx  = y >>> k;
    dy  = x >>> k;
    at  = $signed({2'b0, ATAN_TAB[k]});
    rot = atan_mode ? y[CV_W-1] : ~z[CV_W-1];
    if (rot) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - at;
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy      <= 1'b1;
        done      <= 1'b0;
        atan_mode <= req.atan_mode;
        k         <= '0;
        if (req.atan_mode) begin
          flip <= 1'b0;
          x    <= xin;
          y    <= yin;
          z    <= '0;
        end else begin
          flip <= quad_flip;
          x    <= CORDIC_GAIN_Q30;
          y    <= '0;
          z    <= $signed({{2{ang_fold[31]}}, ang_fold});
        end
      end else if (busy) begin
        x    <= x_next;
        y    <= y_next;
        z    <= z_next;
        k    <= k + IDX_W'(1);
        done <= (k == IDX_W'(CORDIC_STEPS - 1));
        if (k == IDX_W'(CORDIC_STEPS - 1)) begin
          busy    <= 1'b0;
          cos_out <= flip ? -x_next : x_next;
          sin_out <= flip ? -y_next : y_next;
          z_out   <= z_next[CV_W-1] ? '0 : z_next;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: rtl/great_circle_speed_estimator.sv
// Great-circle speed estimator top level: fix/speed channels, register port
// and step sequencer. Depends on gcse_pkg, gcse_ifs, gcse_arith, gcse_cordic.
//
// Position fixes arrive as words on the fix channel (valid/ready). A fix
// flagged first_point is held as the start; other fixes without last_point
// are absorbed. A fix flagged last_point yields one speed word
// on the result channel, in km/s with 16 fraction bits, saturating.
// A single-fix sequence, or a last fix with no start held, gives zero.
// Otherwise the sequencer runs 21 steps on a shared bit-serial
// multiply/divide/square-root unit and an iterative CORDIC: four angle
// conversions and the final division, five CORDIC passes, eight
// multiplies and three square roots, each step passing through an issue
// state and then a wait state until its unit is done. Fixes are taken
// one at a time; ready is low while a speed is being computed or while a
// finished word waits for the output register. The speed word is held
// there until taken; while the receiver stalls, fixes are still absorbed
// and the next speed computed, after which the input stalls too.
// delta_time lives at address 0 and resets to 256 (one second). Reset
// clears the held start and any word in flight.
module great_circle_speed_estimator (
  input  logic        clk,
  input  logic        rst,
  gcse_fix_if.sink    fix,
  gcse_speed_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gcse_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  typedef enum logic [4:0] {
    SP_BANG_LAT1 = 5'd0,
    SP_SC_LAT1   = 5'd1,
    SP_BANG_LAT2 = 5'd2,
    SP_SC_LAT2   = 5'd3,
    SP_BANG_DLAT = 5'd4,
    SP_SC_DLAT   = 5'd5,
    SP_BANG_DLON = 5'd6,
    SP_SC_DLON   = 5'd7,
    SP_SQ_LAT    = 5'd8,
    SP_COS_PROD  = 5'd9,
    SP_SQ_LON    = 5'd10,
    SP_HAV       = 5'd11,
    SP_ROOT_A    = 5'd12,
    SP_ROOT_B    = 5'd13,
    SP_ATAN      = 5'd14,
    SP_PI_MUL    = 5'd15,
    SP_RAD_MUL   = 5'd16,
    SP_SQ_SURF   = 5'd17,
    SP_SQ_ALT    = 5'd18,
    SP_ROOT_DIST = 5'd19,
    SP_SPEED     = 5'd20
  } step_t;

  state_t state;
  step_t  step;

  // Register and held start
  logic [31:0]              delta_time;
  logic signed [LAT_W-1:0]  start_lat;
  logic signed [LON_W-1:0]  start_lon;
  logic signed [ALT_W-1:0]  start_alt;
  logic                     have_start;

  // End fix and intermediate results
  logic signed [LAT_W-1:0]  end_lat;
  logic signed [LON_W-1:0]  end_lon;
  logic signed [ALT_W-1:0]  end_alt;
  logic [31:0]              bang;
  logic signed [CV_W-1:0]   cos1;
  logic signed [CV_W-1:0]   cos2;
  logic signed [CV_W-1:0]   sin_hlat;
  logic signed [CV_W-1:0]   sin_hlon;
  logic signed [CV_W-1:0]   t_lat;
  logic signed [CV_W-1:0]   t_cos;
  logic signed [CV_W-1:0]   t_lon;
  logic [30:0]              hav;
  logic signed [CV_W-1:0]   root_a;
  logic signed [CV_W-1:0]   root_b;
  logic signed [CV_W-1:0]   half_ang;
  logic [CV_W-1:0]          surf_raw;
  logic [31:0]              surf;
  logic [63:0]              sq_surf;
  logic [63:0]              sq_alt;
  logic [31:0]              dist_km;
  logic [31:0]              speed_calc;
  logic [31:0]              speed_word;
  logic                     out_valid;

  // Unit connections
  arith_req_t               areq;
  unit_stat_t               astat;
  logic [63:0]              aopa;
  logic [63:0]              aopb;
  logic [63:0]              ares;
  cordic_req_t              creq;
  unit_stat_t               cstat;
  logic signed [CV_W-1:0]   c_cos;
  logic signed [CV_W-1:0]   c_sin;
  logic signed [CV_W-1:0]   c_z;
  logic                     use_cordic;
  arith_op_t                aop;

  // Input fix with signs applied
  logic signed [LAT_W-1:0]  in_lat;
  logic signed [LON_W-1:0]  in_lon;
  logic                     fix_acc;
  logic                     cfg_wr;

  // Working values
  logic signed [DIFF_W-1:0] d_lat;
  logic signed [DIFF_W-1:0] d_lon;
  logic signed [DIFF_W-1:0] d_alt;
  logic signed [DIFF_W-1:0] bang_src;
  logic                     bang_half;
  logic [DIFF_W-1:0]        bang_mag;
  logic [63:0]              bang_den;
  logic [31:0]              bang_q;
  logic signed [63:0]       prod;
  logic signed [63:0]       prod_q30;
  logic signed [34:0]       hav_sum;
  logic [30:0]              hav_clamp;
  logic [30:0]              hav_comp;
  logic [63:0]              surf_round;

  assign in_lat = fix.lat_south ? -LAT_W'(fix.lat_magnitude) : LAT_W'(fix.lat_magnitude);
  assign in_lon = fix.lon_west  ? -LON_W'(fix.lon_magnitude) : LON_W'(fix.lon_magnitude);

  assign d_lat = DIFF_W'(end_lat) - DIFF_W'(start_lat);
  assign d_lon = DIFF_W'(end_lon) - DIFF_W'(start_lon);
  assign d_alt = DIFF_W'(end_alt) - DIFF_W'(start_alt);

  // Degrees to binary angle: rounded on the magnitude, sign applied after
  always_comb begin
    case (step)
      SP_BANG_LAT1: begin bang_src = DIFF_W'(start_lat); bang_half = 1'b0; end
      SP_BANG_LAT2: begin bang_src = DIFF_W'(end_lat);   bang_half = 1'b0; end
      SP_BANG_DLAT: begin bang_src = d_lat;              bang_half = 1'b1; end
      default:      begin bang_src = d_lon;              bang_half = 1'b1; end
    endcase
  end
  assign bang_mag = bang_src[DIFF_W-1] ? DIFF_W'(-bang_src) : DIFF_W'(bang_src);
  assign bang_den = bang_half ? DEN_HALF : DEN_FULL;
  assign bang_q   = bang_src[DIFF_W-1] ? -ares[31:0] : ares[31:0];

  // Product back to Q30, floored
  assign prod     = $signed(ares);
  assign prod_q30 = prod >>> 30;

  // Haversine term clamped to [0, 1]
  assign hav_sum = 35'(t_lat) + prod_q30[34:0];
  always_comb begin
    if (hav_sum < 0) begin
      hav_clamp = '0;
    end else if (hav_sum > ONE_Q30) begin
      hav_clamp = ONE_Q30[30:0];
    end else begin
      hav_clamp = hav_sum[30:0];
    end
  end
  assign hav_comp   = ONE_Q30[30:0] - hav;
  assign surf_round = ares + 64'h20_0000;

  // Operation and operands of each step
  always_comb begin
    use_cordic = 1'b0;
    aop        = AOP_MUL;
    aopa       = '0;
    aopb       = '0;
    case (step)
      SP_BANG_LAT1, SP_BANG_LAT2, SP_BANG_DLAT, SP_BANG_DLON: begin
        aop  = AOP_DIV;
        aopa = {6'b0, bang_mag, 32'b0} + {1'b0, bang_den[63:1]};
        aopb = bang_den;
      end
      SP_SC_LAT1, SP_SC_LAT2, SP_SC_DLAT, SP_SC_DLON, SP_ATAN: begin
        use_cordic = 1'b1;
      end
      SP_SQ_LAT:  begin aopa = {30'b0, sin_hlat}; aopb = {30'b0, sin_hlat}; end
      SP_COS_PROD: begin aopa = {30'b0, cos1};   aopb = {30'b0, cos2}; end
      SP_SQ_LON:  begin aopa = {30'b0, sin_hlon}; aopb = {30'b0, sin_hlon}; end
      SP_HAV:     begin aopa = {30'b0, t_cos};    aopb = {30'b0, t_lon}; end
      SP_ROOT_A:  begin aop = AOP_SQRT; aopa = {3'b0, hav, 30'b0}; end
      SP_ROOT_B:  begin aop = AOP_SQRT; aopa = {3'b0, hav_comp, 30'b0}; end
      SP_PI_MUL:  begin aopa = {30'b0, PI_Q30}; aopb = {30'b0, half_ang}; end
      SP_RAD_MUL: begin aopa = 64'(EARTH_RADIUS_KM); aopb = {30'b0, surf_raw}; end
      SP_SQ_SURF: begin aopa = {32'b0, surf}; aopb = {32'b0, surf}; end
      SP_SQ_ALT:  begin aopa = {30'b0, CV_W'(d_alt)}; aopb = {30'b0, CV_W'(d_alt)}; end
      SP_ROOT_DIST: begin aop = AOP_SQRT; aopa = sq_surf + sq_alt; end
      SP_SPEED:   begin aop = AOP_DIV; aopa = {16'b0, dist_km, 16'b0}; aopb = {32'b0, delta_time}; end
      default: begin
        aop = AOP_MUL;
      end
    endcase
  end

  assign areq.start     = (state == ST_ISSUE) && !use_cordic;
  assign areq.op        = aop;
  assign creq.start     = (state == ST_ISSUE) && use_cordic;
  assign creq.atan_mode = (step == SP_ATAN);

  gcse_arith u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (areq),
    .opa  (aopa),
    .opb  (aopb),
    .stat (astat),
    .res  (ares)
  );

  gcse_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .req     (creq),
    .ang     (bang),
    .xin     (root_b),
    .yin     (root_a),
    .stat    (cstat),
    .cos_out (c_cos),
    .sin_out (c_sin),
    .z_out   (c_z)
  );

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? delta_time : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_time <= 32'd256;
    end else if (cfg_wr) begin
      delta_time <= pwdata;
    end
  end

  // Handshakes
  assign fix.ready    = (state == ST_IDLE);
  assign fix_acc      = fix.valid && fix.ready;
  assign result.valid = out_valid;
  assign result.speed = speed_word;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= SP_BANG_LAT1;
      have_start <= 1'b0;
      out_valid  <= 1'b0;
      start_lat  <= '0;
      start_lon  <= '0;
      start_alt  <= '0;
    end else begin
      // Output register: loaded from ST_OUT, emptied when taken
      if ((state == ST_OUT) && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (fix_acc) begin
            if (fix.first_point) begin
              start_lat <= in_lat;
              start_lon <= in_lon;
              start_alt <= fix.altitude;
            end
            if (fix.last_point) begin
              have_start <= 1'b0;
              end_lat    <= in_lat;
              end_lon    <= in_lon;
              end_alt    <= fix.altitude;
              step       <= SP_BANG_LAT1;
              if (fix.first_point || !have_start) begin
                speed_calc <= 32'd0;
                state      <= ST_OUT;
              end else begin
                state <= ST_ISSUE;
              end
            end else if (fix.first_point) begin
              have_start <= 1'b1;
            end
          end
        end
        ST_ISSUE: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (astat.done || cstat.done) begin
            case (step)
              SP_BANG_LAT1, SP_BANG_LAT2, SP_BANG_DLAT, SP_BANG_DLON: bang <= bang_q;
              SP_SC_LAT1:   cos1     <= c_cos;
              SP_SC_LAT2:   cos2     <= c_cos;
              SP_SC_DLAT:   sin_hlat <= c_sin;
              SP_SC_DLON:   sin_hlon <= c_sin;
              SP_SQ_LAT:    t_lat    <= prod_q30[CV_W-1:0];
              SP_COS_PROD:  t_cos    <= prod_q30[CV_W-1:0];
              SP_SQ_LON:    t_lon    <= prod_q30[CV_W-1:0];
              SP_HAV:       hav      <= hav_clamp;
              SP_ROOT_A:    root_a   <= $signed(ares[CV_W-1:0]);
              SP_ROOT_B:    root_b   <= $signed(ares[CV_W-1:0]);
              SP_ATAN:      half_ang <= c_z;
              SP_PI_MUL:    surf_raw <= ares[CV_W+29:30];
              SP_RAD_MUL:   surf     <= surf_round[53:22];
              SP_SQ_SURF:   sq_surf  <= ares;
              SP_SQ_ALT:    sq_alt   <= ares;
              SP_ROOT_DIST: dist_km  <= ares[31:0];
              default:      speed_calc <= (ares[63:32] != 32'd0) ? 32'hFFFF_FFFF : ares[31:0];
            endcase
            if (step == SP_SPEED) begin
              state <= ST_OUT;
            end else begin
              step  <= step_t'(step + 5'd1);
              state <= ST_ISSUE;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid || result.ready) begin
            speed_word <= speed_calc;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    (astat.done || cstat.done) |-> (state == ST_WAIT))
    else $error("unit finished outside the wait state");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(astat.busy && cstat.busy))
    else $error("both units busy at once");

  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    fix_acc |-> (!astat.busy && !cstat.busy))
    else $error("fix accepted while a speed is being computed");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= SP_SPEED)
    else $error("sequencer step out of range");

  a_issue_starts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE) |=> (astat.busy || cstat.busy))
    else $error("issued step started no unit");

endmodule

// File: test/great_circle_speed_estimator_test.sv
// Self-checking bench for the great-circle speed estimator: drives position
// fixes and delta_time settings, predicts each speed word and compares it.
// Depends on gcse_pkg, gcse_ifs and the great_circle_speed_estimator RTL.
module great_circle_speed_estimator_test;
  import gcse_pkg::*;

  localparam logic [2:0] ADDR_DELTA_TIME = 3'd0;
  localparam int HOLD_CYCLES = 4000;
  localparam int SETTLE_CYCLES = 40;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [22:0]        lat_magnitude;
    logic               lat_south;
    logic [23:0]        lon_magnitude;
    logic               lon_west;
    logic signed [24:0] altitude;
    logic               first_point;
    logic               last_point;
  } fix_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gcse_fix_if   fix ();
  gcse_speed_if result ();

  great_circle_speed_estimator dut (
    .clk(clk), .rst(rst), .fix(fix.sink), .result(result.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fix_word_t   fix_queue[$];
  logic [31:0] speed_queue[$];
  idle_mode_t  idle_mode = IDLE_NONE;
  int          fails = 0;
  logic        hold_req = 1'b0;
  int          hold_cnt = 0;

  // Predictor state
  logic [31:0] cur_delta_time = 32'd256;
  longint      st_lat = 0, st_lon = 0, st_alt = 0;
  bit          st_held = 0;

  initial begin
    fix.valid = 1'b0;
    fix.lat_magnitude = '0; fix.lat_south = 1'b0;
    fix.lon_magnitude = '0; fix.lon_west = 1'b0;
    fix.altitude = '0; fix.first_point = 1'b0; fix.last_point = 1'b0;
    result.ready = 1'b0;
  end

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Degrees (16 fraction bits) to binary angle, rounded on the magnitude
  function automatic logic [31:0] to_bang(input longint d, input longint unsigned den);
    longint unsigned m;
    logic [31:0] r;
    m = (d < 0) ? longint'(-d) : d;
    r = 32'(((m << 32) + den / 2) / den);
    return (d < 0) ? 32'(0 - r) : r;
  endfunction

  function automatic void sin_cos(input logic [31:0] ang, output longint c,
                                  output longint s);
    bit flip;
    longint x, y, z, dx, dy;
    int k;
    flip = 0;
    x = CORDIC_GAIN_Q30;
    y = 0;
    if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
      ang = ang + 32'h80000000;
      flip = 1;
    end
    z = longint'($signed(ang));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      k = i & 31;
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[k]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[k]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Vectoring CORDIC, first quadrant, binary angle out
  function automatic longint atan_quad(input longint y, input longint x);
    longint z, dx, dy;
    int k;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      k = i & 31;
      dx = y >>> k;
      dy = x >>> k;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[k]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[k]);
      end
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic logic [31:0] great_circle_speed(input longint lat2, input longint lon2,
                                                     input longint alt2);
    longint c1, s1, c2, s2, ch, sh_lat, sh_lon, a, z, dalt, one;
    longint unsigned surf, dist_km, sa, sb, q, pi;
    one = ONE_Q30;
    pi = PI_Q30;
    sin_cos(to_bang(st_lat, DEN_FULL), c1, s1);
    sin_cos(to_bang(lat2, DEN_FULL), c2, s2);
    sin_cos(to_bang(lat2 - st_lat, DEN_HALF), ch, sh_lat);
    sin_cos(to_bang(lon2 - st_lon, DEN_HALF), ch, sh_lon);
    a = ((sh_lat * sh_lat) >>> 30) +
        ((((c1 * c2) >>> 30) * ((sh_lon * sh_lon) >>> 30)) >>> 30);
    if (a < 0) a = 0;
    if (a > one) a = one;
    sa = isqrt(longint'(a) << 30);
    sb = isqrt(longint'(one - a) << 30);
    z = atan_quad(sa, sb);
    surf = (pi * longint'(z)) >> 30;
    surf = (longint'(EARTH_RADIUS_KM) * surf + (64'd1 << 21)) >> 22;
    dalt = alt2 - st_alt;
    dist_km = isqrt(surf * surf + longint'(dalt * dalt));
    if (cur_delta_time == 0) return 32'hFFFFFFFF;
    q = (dist_km << 16) / cur_delta_time;
    return (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
  endfunction

  // Appends a fix word to the pending queue
  function automatic void add_fix(input fix_word_t w);
    fix_queue = {fix_queue, w};
  endfunction

  // Updates the held start and queues the speed a last fix should give
  function automatic void predict_fix(input fix_word_t w);
    longint lat, lon, alt;
    logic [31:0] exp_word;
    lat = w.lat_south ? -longint'(w.lat_magnitude) : longint'(w.lat_magnitude);
    lon = w.lon_west ? -longint'(w.lon_magnitude) : longint'(w.lon_magnitude);
    alt = longint'(w.altitude);
    if (w.first_point) begin
      st_lat = lat; st_lon = lon; st_alt = alt; st_held = 1;
    end
    if (w.last_point) begin
      exp_word = (!w.first_point && st_held) ? great_circle_speed(lat, lon, alt) : 32'd0;
      speed_queue = {speed_queue, exp_word};
      st_held = 0;
    end
  endfunction

  function automatic bit src_idle();
    if (idle_mode == IDLE_SRC) return $urandom_range(99) < 62;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 18;
    return 0;
  endfunction

  function automatic bit snk_idle();
    if (idle_mode == IDLE_SNK) return $urandom_range(99) < 62;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 18;
    return 0;
  endfunction

  // Fix driver: a new word goes out once the current one is taken
  always @(posedge clk) begin
    fix_word_t w;
    if (rst) begin
      fix.valid <= 1'b0;
    end else if (!fix.valid || fix.ready) begin
      if (fix.valid) begin
        predict_fix({fix.lat_magnitude, fix.lat_south, fix.lon_magnitude, fix.lon_west,
                     fix.altitude, fix.first_point, fix.last_point});
      end
      if (fix_queue.size() != 0 && !src_idle()) begin
        w = fix_queue.pop_front();
        fix.valid <= 1'b1;
        fix.lat_magnitude <= w.lat_magnitude;
        fix.lat_south <= w.lat_south;
        fix.lon_magnitude <= w.lon_magnitude;
        fix.lon_west <= w.lon_west;
        fix.altitude <= w.altitude;
        fix.first_point <= w.first_point;
        fix.last_point <= w.last_point;
      end else begin
        fix.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off counter
  always @(posedge clk) begin
    if (hold_req) hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  // Speed monitor
  always @(posedge clk) begin
    logic [31:0] exp_speed;
    if (!rst && result.valid && result.ready) begin
      if (speed_queue.size() == 0) begin
        $display("%0t: unexpected speed word, expected none, actual %h",
                 $time, result.speed);
        fails++;
      end else begin
        exp_speed = speed_queue.pop_front();
        if (result.speed !== exp_speed) begin
          $display("%0t: speed mismatch, expected %h, actual %h",
                   $time, exp_speed, result.speed);
          fails++;
        end
      end
    end
    result.ready <= !rst && hold_cnt == 0 && !hold_req && !snk_idle();
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_DELTA_TIME) cur_delta_time = data;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (fix_queue.size() != 0 || fix.valid || speed_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic fix_word_t make_fix(input bit first, input bit last);
    fix_word_t w;
    w.lat_magnitude = ($urandom_range(9) == 0) ? 23'($urandom) : 23'($urandom_range(5898240));
    w.lon_magnitude = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(11796480));
    w.lat_south = 1'($urandom);
    w.lon_west = 1'($urandom);
    case ($urandom_range(3))
      0: w.altitude = 25'(int'($urandom_range(17039359)) - 262144);
      default: w.altitude = 25'(int'($urandom_range(4000)) - 500);
    endcase
    w.first_point = first;
    w.last_point = last;
    return w;
  endfunction

  function automatic fix_word_t put_fix(input int lat, input int lon, input int alt,
                                        input bit first, input bit last);
    fix_word_t w;
    w.lat_magnitude = 23'(lat < 0 ? -lat : lat); w.lat_south = lat < 0;
    w.lon_magnitude = 24'(lon < 0 ? -lon : lon); w.lon_west = lon < 0;
    w.altitude = 25'(alt);
    w.first_point = first;
    w.last_point = last;
    return w;
  endfunction

  // Random sequences: mostly well formed, some noise
  task automatic queue_random(input int n_items);
    int cnt;
    int n_mid;
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(99) < 15) begin
        add_fix(make_fix(1'($urandom), 1'($urandom)));
        cnt++;
      end else begin
        n_mid = $urandom_range(3);
        add_fix(make_fix(1, 0));
        repeat (n_mid) add_fix(make_fix(0, 0));
        add_fix(make_fix(0, 1));
        cnt += n_mid + 2;
      end
    end
  endtask

  // Stimulus
  initial begin
    idle_mode_t modes[6];
    logic [31:0] dts[6];
    modes = '{IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH, IDLE_NONE, IDLE_BOTH};
    dts = '{32'd1, 32'hFFFFFFFF, 32'd0, 32'd256, 32'd0, 32'd0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed fixes at reset delta_time
    add_fix(put_fix(0, 0, 0, 1, 1));                  // single fix
    add_fix(put_fix(100, 200, 5, 0, 1));              // last, no start
    add_fix(put_fix(5898240, 11796480, 16777215, 1, 0));
    add_fix(put_fix(-5898240, -11796480, -262144, 0, 1));
    add_fix(put_fix(1000, 1000, 0, 1, 0));
    add_fix(put_fix(3000000, 3000000, 100, 1, 0));    // start replaced
    add_fix(put_fix(0, 0, 0, 0, 0));                  // ignored
    add_fix(put_fix(-3000000, 11796480, 100, 0, 1));
    add_fix(put_fix(0, 0, 0, 1, 0));
    add_fix(put_fix(0, 11796480, 0, 0, 1));           // antipodal
    add_fix(put_fix(8388607, 16777215, 0, 1, 0));     // wrapping angles
    add_fix(put_fix(-8388607, -16777215, -1, 0, 1));
    add_fix(put_fix(0, 0, 0, 1, 0));
    add_fix(put_fix(0, 0, 0, 0, 1));                  // no movement
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      dts[4] = $urandom;
      dts[5] = $urandom_range(4096, 1);
      reg_write(ADDR_DELTA_TIME, dts[p]);
      idle_mode = modes[p];
      queue_random(250);
      if (p == 1) begin
        // Long receiver stall while fixes keep coming
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      wait_drained();
    end

    if (fails == 0)
      $display("[great_circle_speed_estimator] OK");
    else
      $display("[great_circle_speed_estimator] ERROR");
    $finish;
  end

  // Timeout
  initial begin
    #100000000;
    $display("[great_circle_speed_estimator] ERROR");
    $finish;
  end

endmodule
